// ===== sv/json_key_string_extractor_macros.svh =====
// Assertion helpers for the extractor back end.
`ifndef JSON_KEY_STRING_EXTRACTOR_MACROS_SVH
`define JSON_KEY_STRING_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JKSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JKSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jkse_pkg.sv =====
package jkse_pkg;

  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_LEN_W     = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;
  localparam int QUEUE_DEPTH   = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd2;

  // Character codes
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_VT     = 8'h0B;

  typedef enum logic [2:0] {
    ST_FOUND        = 3'd0,
    ST_ABSENT       = 3'd1,
    ST_NO_COLON     = 3'd2,
    ST_NOT_STRING   = 3'd3,
    ST_UNTERMINATED = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] value_byte;
    status_t    status;
    logic       last;
  } out_item_t;

  // Classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       is_ws;
    logic       is_colon;
    logic       is_quote;
    logic       is_bslash;
  } cls_t;

  function automatic cls_t classify(input in_item_t item);
    cls_t c;
    c.text_byte   = item.text_byte;
    c.end_of_text = item.end_of_text;
    c.is_ws       = (item.text_byte == CH_SPACE) || (item.text_byte == CH_TAB) ||
                    (item.text_byte == CH_CR)    || (item.text_byte == CH_LF)  ||
                    (item.text_byte == CH_FF)    || (item.text_byte == CH_VT);
    c.is_colon    = (item.text_byte == CH_COLON);
    c.is_quote    = (item.text_byte == CH_QUOTE);
    c.is_bslash   = (item.text_byte == CH_BSLASH);
    return c;
  endfunction

endpackage

// ===== sv/jkse_front.sv =====
module jkse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  jkse_pkg::in_item_t in_data,
  output logic              head_valid,
  output jkse_pkg::cls_t    head,
  input  logic              pop
);
  import jkse_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cls_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;

  assign in_ready   = (count != CntW'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Classify on the way in so the back only sees flags
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classify(in_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/jkse_back.sv =====
`include "json_key_string_extractor_macros.svh"

module jkse_back #(
  parameter int MaxKeyBytes = jkse_pkg::MAX_KEY_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [jkse_pkg::KEY_LEN_W-1:0]      key_length,
  input  logic [MaxKeyBytes-1:0][7:0]         key,
  input  logic                                head_valid,
  input  jkse_pkg::cls_t                      head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output jkse_pkg::out_item_t                 out_data
);
  import jkse_pkg::*;

  localparam int WinDepth = MaxKeyBytes + 2;
  localparam int SeenW    = $clog2(WinDepth + 1);
  localparam int KlenW    = $clog2(MaxKeyBytes + 1);
  localparam int KeyIdxW  = (MaxKeyBytes > 1) ? $clog2(MaxKeyBytes) : 1;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_COLON  = 6'b000010,
    PH_QUOTE  = 6'b000100,
    PH_VALUE  = 6'b001000,
    PH_ESCAPE = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t                     phase, phase_next;
  logic [SeenW-1:0]           bytes_seen, seen_next, seen_inc;
  logic [WinDepth-1:0][7:0]   window;
  logic [WinDepth-1:0][7:0]   win_shift;
  logic [KlenW-1:0]           klen;
  logic                       match;
  logic                       step;
  logic                       shift_en;
  logic                       res_valid;
  out_item_t                  res;

  assign step = head_valid && (!out_valid || out_ready);
  assign pop  = step;

  // Clamp oversized key lengths
  assign klen = (key_length > KEY_LEN_W'(MaxKeyBytes)) ? KlenW'(MaxKeyBytes)
                                                      : KlenW'(key_length);

  assign seen_inc = (bytes_seen == SeenW'(WinDepth)) ? bytes_seen : bytes_seen + 1'b1;

  // Window after taking the new byte; entry 0 is the newest
  always_comb begin
    win_shift[0] = head.text_byte;
    for (int j = 1; j < WinDepth; j++) begin
      win_shift[j] = window[j-1];
    end
  end

  // Parallel compare: quote, key bytes newest-last, quote
  always_comb begin
    logic [KlenW-1:0] kidx;
    logic [7:0]       want;
    logic             ok;
    match = (int'(seen_inc) >= int'(klen) + 2);
    for (int j = 0; j < WinDepth; j++) begin
      kidx = klen - KlenW'(j);
      want = CH_QUOTE;
      ok   = 1'b1;
      if (j == 0 || j == int'(klen) + 1) begin
        ok = (win_shift[j] == CH_QUOTE);
      end else if (j <= int'(klen)) begin
        want = key[kidx[KeyIdxW-1:0]];
        ok   = (win_shift[j] == want);
      end
      match = match && ok;
    end
  end

  always_comb begin
    logic    finished;
    logic    have_value;
    logic    skip;
    logic    clear;
    status_t st;
    phase_next = phase;
    seen_next  = bytes_seen;
    shift_en   = 1'b0;
    finished   = 1'b0;
    have_value = 1'b0;
    skip       = 1'b0;
    clear      = 1'b0;
    st         = ST_FOUND;
    case (phase)
      PH_SEARCH: begin
        shift_en  = 1'b1;
        seen_next = seen_inc;
        if (match) begin
          phase_next = PH_COLON;
        end
      end
      PH_COLON: begin
        if (head.is_colon) begin
          phase_next = PH_QUOTE;
        end else if (!head.is_ws) begin
          finished = 1'b1;
          st       = ST_NO_COLON;
        end
      end
      PH_QUOTE: begin
        if (head.is_quote) begin
          phase_next = PH_VALUE;
        end else if (!head.is_ws) begin
          finished = 1'b1;
          st       = ST_NOT_STRING;
        end
      end
      PH_VALUE: begin
        if (head.is_bslash) begin
          phase_next = PH_ESCAPE;
        end else if (head.is_quote) begin
          finished = 1'b1;
          st       = ST_FOUND;
        end else begin
          have_value = 1'b1;
        end
      end
      PH_ESCAPE: begin
        phase_next = PH_VALUE;
        have_value = 1'b1;
      end
      default: begin
        skip  = 1'b1;
        clear = head.end_of_text;
      end
    endcase

    // End of text before a finish: status follows the phase reached
    if (!skip && !finished && head.end_of_text) begin
      finished = 1'b1;
      case (phase_next)
        PH_SEARCH: st = ST_ABSENT;
        PH_COLON:  st = ST_NO_COLON;
        PH_QUOTE:  st = ST_NOT_STRING;
        default:   st = ST_UNTERMINATED;
      endcase
    end

    if (finished) begin
      if (head.end_of_text) begin
        clear = 1'b1;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (clear) begin
      phase_next = PH_SEARCH;
      seen_next  = '0;
    end

    res_valid = finished || have_value;
    if (finished) begin
      res.is_status  = 1'b1;
      res.value_byte = '0;
      res.status     = st;
      res.last       = 1'b1;
    end else begin
      res.is_status  = 1'b0;
      res.value_byte = head.text_byte;
      res.status     = ST_FOUND;
      res.last       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && shift_en) begin
      window <= win_shift;
    end
    if (step && res_valid) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEARCH;
      bytes_seen <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (step) begin
        phase      <= phase_next;
        bytes_seen <= seen_next;
      end
      if (step && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `JKSE_ASSERT_NOW(a_status_is_last, out_valid, out_data.is_status == out_data.last, "status and last disagree")
  `JKSE_ASSERT_NOW(a_value_status_zero, out_valid && !out_data.is_status, out_data.status == ST_FOUND, "value byte carries a status")
  `JKSE_ASSERT_NOW(a_seen_bound, 1'b1, bytes_seen <= SeenW'(WinDepth), "bytes_seen past window depth")
  `JKSE_ASSERT_NEXT(a_eot_clears, step && head.end_of_text, phase == PH_SEARCH && bytes_seen == '0, "text end did not clear state")

endmodule

// ===== sv/json_key_string_extractor.sv =====
// JSON key/string-value extractor.
// Input channel (in_valid/in_ready/in_data): one JSON text byte per transfer,
// end_of_text set on the final byte of a text. The block finds the first
// quoted occurrence of the configured key, then expects optional whitespace,
// a colon, whitespace and an opening quote, and streams the string value.
// Output channel (out_valid/out_ready/out_data): value bytes (is_status 0),
// then one status transfer with last set. On any status other than found
// the receiver drops value bytes it already took for that text.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0
// key length, 1 key bytes 0..7, 2 key bytes 8..15; always ready, write only
// while idle.
// Throughput: one byte per cycle while the receiver is ready; the key compare
// over the byte window is combinational. A byte that yields output passes
// the queue stage, then the output register, before out_valid rises. When
// the receiver stalls, the output register holds and the two-entry queue
// fills, then in_ready drops. Reset clears the key registers, the queue and
// the parser state; no clearing sweep is needed.
module json_key_string_extractor #(
  parameter int MaxKeyBytes = jkse_pkg::MAX_KEY_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  jkse_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output jkse_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jkse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [jkse_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import jkse_pkg::*;

  logic [KEY_LEN_W-1:0]        key_length;
  logic [CFG_DATA_W-1:0]       key_bytes_low;
  logic [CFG_DATA_W-1:0]       key_bytes_high;
  logic [2*CFG_DATA_W-1:0]     key_full;
  logic [MaxKeyBytes-1:0][7:0] key;
  logic                        head_valid;
  cls_t                        head;
  logic                        pop;

  // Configuration writes take effect in the next cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= '0;
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LENGTH: key_length     <= cfg_data[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_bytes_low  <= cfg_data;
        REG_KEY_HIGH:   key_bytes_high <= cfg_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Key byte 0 sits in the lowest bits
  assign key_full = {key_bytes_high, key_bytes_low};
  assign key      = key_full[MaxKeyBytes*8-1:0];

  // Front: accept and classify bytes into a short queue
  jkse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: key window match, phase tracking and output register
  jkse_back #(
    .MaxKeyBytes (MaxKeyBytes)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .key_length (key_length),
    .key        (key),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
